FILE: sv/min_heap_priority_queue_unit_assert.svh
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// concurrent check macros, empty in synthesis builds
`ifndef SYNTHESIS
`define MHPQ_ASSERT_SAME(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("min heap queue check failed");
`define MHPQ_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("min heap queue check failed");
`else
`define MHPQ_ASSERT_SAME(name, clk, rst, pre, post)
`define MHPQ_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

FILE: sv/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int KEY_W  = 31;
  localparam int PAY_W  = 24;

  // request opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [CNT_W-1:0] fill;
  } result_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

endpackage

FILE: sv/mhpq_ram.sv
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: sv/mhpq_sift.sv
`timescale 1ns / 1ps

module mhpq_sift (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [mhpq_pkg::KEY_W-1:0] key,
  input  logic [mhpq_pkg::PAY_W-1:0] payload,
  output mhpq_pkg::mem_req_t        mem_req,
  input  mhpq_pkg::entry_t          rdata0,
  input  mhpq_pkg::entry_t          rdata1,
  output logic                      res_valid,
  input  logic                      res_ready,
  output mhpq_pkg::result_t         res
);

  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] pos;
  entry_t            item;
  status_t           res_status;
  entry_t            res_item;
  logic              vl;
  logic              vr;

  logic [ADDR_W:0]   lc;
  logic [ADDR_W:0]   rc;
  logic              vl_c;
  logic              vr_c;
  logic              up_move;
  logic              sel_l;
  logic              sel_r;
  logic [KEY_W-1:0]  best_key;

  // child slots of the hole and their presence
  assign lc   = {pos, 1'b0};
  assign rc   = {pos, 1'b1};
  assign vl_c = (pos != '0) && (CNT_W'(lc) < count);
  assign vr_c = CNT_W'(rc) < count;

  // sift-up: parent moves down only past a strictly greater key
  assign up_move = rdata0.key > item.key;

  // sift-down: strictly smaller child, left wins ties
  assign sel_l    = vl && (rdata0.key < item.key);
  assign best_key = sel_l ? rdata0.key : item.key;
  assign sel_r    = vr && (rdata1.key < best_key);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: res_status, key: res_item.key,
                       payload: res_item.payload, fill: count};

  // memory requests per state
  always_comb begin
    mem_req = '0;
    unique case (state)
      S_UP_CHK: begin
        if (pos == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = item;
        end else begin
          mem_req.re     = 1'b1;
          mem_req.raddr0 = pos >> 1;
        end
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = up_move ? rdata0 : item;
      end
      S_POP_RD: begin
        mem_req.re     = 1'b1;
        mem_req.raddr0 = '0;
        mem_req.raddr1 = count[ADDR_W-1:0];
      end
      S_DN_CHK: begin
        if (vl_c || vr_c) begin
          mem_req.re     = 1'b1;
          mem_req.raddr0 = lc[ADDR_W-1:0];
          mem_req.raddr1 = rc[ADDR_W-1:0];
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = item;
        end
      end
      S_DN_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        if (sel_r) begin
          mem_req.wdata = rdata1;
        end else if (sel_l) begin
          mem_req.wdata = rdata0;
        end else begin
          mem_req.wdata = item;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_status <= ST_OK;
            res_item   <= '0;
            item       <= '{key: key, payload: payload};
            if (op == OP_PUSH) begin
              if (count == CNT_W'(DEPTH)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                pos   <= count[ADDR_W-1:0];
                count <= count + 1'b1;
                state <= S_UP_CHK;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                count <= count - 1'b1;
                state <= S_POP_RD;
              end
            end
          end
        end
        S_UP_CHK: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos   <= pos >> 1;
            state <= S_UP_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_RD: begin
          state <= S_POP_LD;
        end
        S_POP_LD: begin
          res_item <= rdata0;
          item     <= rdata1;
          pos      <= '0;
          state    <= (count == '0) ? S_DONE : S_DN_CHK;
        end
        S_DN_CHK: begin
          if (vl_c || vr_c) begin
            vl    <= vl_c;
            vr    <= vr_c;
            state <= S_DN_CMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_CMP: begin
          if (sel_r) begin
            pos   <= rc[ADDR_W-1:0];
            state <= S_DN_CHK;
          end else if (sel_l) begin
            pos   <= lc[ADDR_W-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/min_heap_priority_queue_unit.sv
// binary min-heap queue, one request at a time, heap held in a 2-read 1-write ram
// push: the new entry climbs from the last slot past every strictly greater parent
// pop: returns the root; unless now empty, the last entry sinks past smaller children
// rejected push or pop skips the ram; the sift loop through the ram sets the rate
// a result waits in an output register while the next request is taken
// rst (synchronous) empties the heap; ram contents are left as they are
`timescale 1ns / 1ps
`include "min_heap_priority_queue_unit_assert.svh"

module min_heap_priority_queue_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [mhpq_pkg::KEY_W-1:0] key,
  input  logic [mhpq_pkg::PAY_W-1:0] payload,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [mhpq_pkg::KEY_W-1:0] out_key,
  output logic [mhpq_pkg::PAY_W-1:0] out_payload,
  output logic [mhpq_pkg::CNT_W-1:0] fill_count
);

  import mhpq_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata0;
  entry_t   rdata1;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  // heap storage
  mhpq_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk    (clk),
    .re     (mem_req.re),
    .raddr0 (mem_req.raddr0),
    .raddr1 (mem_req.raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1),
    .we     (mem_req.we),
    .waddr  (mem_req.waddr),
    .wdata  (mem_req.wdata)
  );

  // push and pop sequencer
  mhpq_sift u_sift (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key       (key),
    .payload   (payload),
    .mem_req   (mem_req),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid   <= 1'b1;
      status      <= res.status;
      out_key     <= res.key;
      out_payload <= res.payload;
      fill_count  <= res.fill;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `MHPQ_ASSERT_SAME(a_fill_range, clk, rst, out_valid, fill_count <= CNT_W'(DEPTH))
  `MHPQ_ASSERT_SAME(a_reject_zero, clk, rst, out_valid && (status != ST_OK),
                    (out_key == '0) && (out_payload == '0))
  `MHPQ_ASSERT_SAME(a_full_count, clk, rst, out_valid && (status == ST_FULL),
                    fill_count == CNT_W'(DEPTH))
  `MHPQ_ASSERT_NEXT(a_one_request, clk, rst, in_valid && in_ready, !in_ready)

endmodule
